// ----- hdl/pfr_pkg.sv -----
package pfr_pkg;

  // Table geometry
  localparam int unsigned NUM_FRAMES = 8;
  localparam int unsigned PAGE_BITS  = 20;

  localparam int unsigned PAGE_W  = 20;
  localparam int unsigned STAMP_W = 32;
  localparam int unsigned CNT_W   = 32;
  localparam int unsigned LFSR_W  = 16;
  localparam int unsigned IDX_W   = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
  localparam int unsigned FCNT_W  = $clog2(NUM_FRAMES + 1);
  localparam int unsigned FRAMES_W = 4;
  localparam int unsigned CFG_W   = 16;

  localparam logic [PAGE_W-1:0] PAGE_MASK =
      (PAGE_BITS >= PAGE_W) ? {PAGE_W{1'b1}} : PAGE_W'((64'd1 << PAGE_BITS) - 64'd1);

  // Configuration register indexes
  localparam logic [1:0] CFG_POLICY = 2'd0;
  localparam logic [1:0] CFG_FRAMES = 2'd1;
  localparam logic [1:0] CFG_SEED   = 2'd2;

  // Replacement policies; the unused code behaves as random
  localparam logic [1:0] POL_FIFO   = 2'd0;
  localparam logic [1:0] POL_LRU    = 2'd1;
  localparam logic [1:0] POL_RANDOM = 2'd2;

  localparam logic [FRAMES_W-1:0] FRAMES_RESET = FRAMES_W'(NUM_FRAMES);
  localparam logic [LFSR_W-1:0]   SEED_RESET   = 16'd44257;
  localparam logic [LFSR_W-1:0]   LFSR_TAPS    = 16'hB400;

  typedef struct packed {
    logic [PAGE_W-1:0]  page;
    logic [STAMP_W-1:0] stamp;
  } frame_t;

  localparam int unsigned FRAME_W = $bits(frame_t);

  typedef struct packed {
    logic              start;
    logic [LFSR_W-1:0] dividend;
    logic [FCNT_W-1:0] divisor;
  } mod_req_t;

  typedef struct packed {
    logic             done;
    logic [IDX_W-1:0] rem;
  } mod_rsp_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    sat_inc = (v == {CNT_W{1'b1}}) ? v : v + CNT_W'(1);
  endfunction

  function automatic logic [LFSR_W-1:0] lfsr_step(input logic [LFSR_W-1:0] v);
    logic [LFSR_W-1:0] s;
    s = v >> 1;
    if (v[0]) s = s ^ LFSR_TAPS;
    lfsr_step = s;
  endfunction

endpackage

// ----- hdl/pfr_ram.sv -----
module pfr_ram #(
  parameter int unsigned DEPTH = 8,
  parameter int unsigned WIDTH = 52
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                        wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                        rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hdl/pfr_mod_unit.sv -----
module pfr_mod_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  pfr_pkg::mod_req_t  req_i,
  output pfr_pkg::mod_rsp_t  rsp_o
);

  localparam int unsigned CW = $clog2(pfr_pkg::LFSR_W);

  logic                        busy_q, busy_d;
  logic                        done_q, done_d;
  logic [CW-1:0]               cnt_q, cnt_d;
  logic [pfr_pkg::LFSR_W-1:0]  shift_q, shift_d;
  logic [pfr_pkg::FCNT_W-1:0]  div_q, div_d;
  logic [pfr_pkg::FCNT_W-1:0]  rem_q, rem_d;
  logic [pfr_pkg::FCNT_W:0]    trial;

  // Restoring remainder, one dividend bit per cycle, MSB first
  always_comb begin
    busy_d  = busy_q;
    done_d  = 1'b0;
    cnt_d   = cnt_q;
    shift_d = shift_q;
    div_d   = div_q;
    rem_d   = rem_q;
    trial   = {rem_q, shift_q[pfr_pkg::LFSR_W-1]};
    if (req_i.start) begin
      busy_d  = 1'b1;
      cnt_d   = CW'(pfr_pkg::LFSR_W - 1);
      shift_d = req_i.dividend;
      div_d   = req_i.divisor;
      rem_d   = '0;
    end else if (busy_q) begin
      if (trial >= {1'b0, div_q}) begin
        trial = trial - {1'b0, div_q};
      end
      rem_d   = trial[pfr_pkg::FCNT_W-1:0];
      shift_d = shift_q << 1;
      cnt_d   = cnt_q - CW'(1);
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    shift_q <= shift_d;
    div_q   <= div_d;
    rem_q   <= rem_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.rem  = rem_q[pfr_pkg::IDX_W-1:0];

endmodule

// ----- hdl/page_frame_replacement.sv -----
// Page frame replacement unit. Each page access word is looked up in a table of
// up to NUM_FRAMES resident frames held in one synchronous RAM ({page, stamp}
// per entry), read one entry per cycle. A hit counts and, under LRU, refreshes
// the stamp; a miss fills the next free frame or evicts a victim chosen by
// FIFO, LRU (smallest stamp, lowest slot on ties) or a 16-bit Galois LFSR.
// One access is in flight at a time. A random eviction also waits on the
// bit-serial remainder unit that reduces the LFSR value modulo n, the
// number of filled frames. The result word is held in an output register,
// so a new access is taken while the previous result waits.
// Configuration writes are taken at any time but are meant for idle periods;
// writing the seed reloads the LFSR (a zero seed loads 1).
module page_frame_replacement (
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_addr_i,
  input  logic [15:0] cfg_data_i,

  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // [19:0] page_number

  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [87:0] m_axis_tdata,   // [19:0] evicted_page, [51:20] hit_total,
                                      // [83:52] miss_total
  output logic [1:0]  m_axis_tuser    // [0] is_hit, [1] did_replace
);

  localparam int unsigned IW = pfr_pkg::IDX_W;
  localparam int unsigned FW = pfr_pkg::FCNT_W;
  localparam int unsigned CMP_W = (FW > pfr_pkg::FRAMES_W) ? FW : pfr_pkg::FRAMES_W;

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_SCAN   = 8'b0000_0010,
    S_DECIDE = 8'b0000_0100,
    S_MOD    = 8'b0000_1000,
    S_VREAD  = 8'b0001_0000,
    S_VWRITE = 8'b0010_0000,
    S_HIT    = 8'b0100_0000,
    S_OUT    = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  logic [1:0]                    policy_q, policy_d;
  logic [pfr_pkg::FRAMES_W-1:0]  frames_q, frames_d;
  logic [pfr_pkg::LFSR_W-1:0]    lfsr_q, lfsr_d;
  logic [FW-1:0]                 filled_q, filled_d;
  logic [IW-1:0]                 oldest_q, oldest_d;
  logic [pfr_pkg::CNT_W-1:0]     access_q, access_d;
  logic [pfr_pkg::CNT_W-1:0]     hits_q, hits_d;
  logic [pfr_pkg::CNT_W-1:0]     misses_q, misses_d;

  logic [pfr_pkg::PAGE_W-1:0]    page_q, page_d;
  logic [IW-1:0]                 scan_q, scan_d;
  logic [IW-1:0]                 slot_q, slot_d;
  logic [pfr_pkg::STAMP_W-1:0]   best_q, best_d;
  logic [IW-1:0]                 best_idx_q, best_idx_d;
  logic                          is_hit_q, is_hit_d;
  logic                          repl_q, repl_d;
  logic [pfr_pkg::PAGE_W-1:0]    evict_q, evict_d;

  logic                          m_valid_q, m_valid_d;
  logic                          m_hit_q, m_repl_q;
  logic [pfr_pkg::PAGE_W-1:0]    m_evict_q;
  logic [pfr_pkg::CNT_W-1:0]     m_hits_q, m_misses_q;
  logic                          out_load;

  logic                          ram_we;
  logic [IW-1:0]                 ram_waddr, ram_raddr;
  pfr_pkg::frame_t               ram_wdata, ram_rdata;
  logic [pfr_pkg::FRAME_W-1:0]   ram_rdata_raw;

  pfr_pkg::mod_req_t             mod_req;
  pfr_pkg::mod_rsp_t             mod_rsp;

  logic [FW-1:0]                 limit;
  logic                          scan_last;
  logic [IW-1:0]                 fifo_slot;
  logic [pfr_pkg::LFSR_W-1:0]    lfsr_next;
  logic                          in_accept;

  pfr_ram #(
    .DEPTH (pfr_pkg::NUM_FRAMES),
    .WIDTH (pfr_pkg::FRAME_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata_raw)
  );

  assign ram_rdata = pfr_pkg::frame_t'(ram_rdata_raw);

  pfr_mod_unit u_mod (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mod_req),
    .rsp_o  (mod_rsp)
  );

  // Usable frame count, clamped to 1..NUM_FRAMES
  always_comb begin
    if (frames_q == '0) begin
      limit = FW'(1);
    end else if (CMP_W'(frames_q) > CMP_W'(pfr_pkg::NUM_FRAMES)) begin
      limit = FW'(pfr_pkg::NUM_FRAMES);
    end else begin
      limit = FW'(frames_q);
    end
  end

  assign scan_last = (FW'(scan_q) + FW'(1)) == filled_q;
  assign fifo_slot = (FW'(oldest_q) >= filled_q) ? '0 : oldest_q;
  assign lfsr_next = pfr_pkg::lfsr_step(lfsr_q);
  assign in_accept = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == S_IDLE);
  assign out_load = (state_q == S_OUT) && (!m_valid_q || m_axis_tready);

  always_comb begin
    state_d    = state_q;
    policy_d   = policy_q;
    frames_d   = frames_q;
    lfsr_d     = lfsr_q;
    filled_d   = filled_q;
    oldest_d   = oldest_q;
    access_d   = access_q;
    hits_d     = hits_q;
    misses_d   = misses_q;
    page_d     = page_q;
    scan_d     = scan_q;
    slot_d     = slot_q;
    best_d     = best_q;
    best_idx_d = best_idx_q;
    is_hit_d   = is_hit_q;
    repl_d     = repl_q;
    evict_d    = evict_q;

    ram_we          = 1'b0;
    ram_waddr       = slot_q;
    ram_wdata.page  = page_q;
    ram_wdata.stamp = access_q;
    ram_raddr       = '0;

    mod_req.start    = 1'b0;
    mod_req.dividend = lfsr_next;
    mod_req.divisor  = filled_q;

    if (cfg_we_i) begin
      unique case (cfg_addr_i)
        pfr_pkg::CFG_POLICY: policy_d = cfg_data_i[1:0];
        pfr_pkg::CFG_FRAMES: frames_d = cfg_data_i[pfr_pkg::FRAMES_W-1:0];
        pfr_pkg::CFG_SEED:   lfsr_d = (cfg_data_i == '0) ? pfr_pkg::LFSR_W'(1) : cfg_data_i;
        default: ;
      endcase
    end

    unique case (state_q)
      S_IDLE: begin
        ram_raddr = '0;
        if (in_accept) begin
          page_d   = s_axis_tdata[pfr_pkg::PAGE_W-1:0] & pfr_pkg::PAGE_MASK;
          access_d = access_q + pfr_pkg::CNT_W'(1);
          scan_d   = '0;
          is_hit_d = 1'b0;
          repl_d   = 1'b0;
          evict_d  = '0;
          state_d  = (filled_q == '0) ? S_DECIDE : S_SCAN;
        end
      end
      S_SCAN: begin
        // read data belongs to entry scan_q; prefetch the next one
        ram_raddr = scan_q + IW'(1);
        if ((scan_q == '0) || (ram_rdata.stamp < best_q)) begin
          best_d     = ram_rdata.stamp;
          best_idx_d = scan_q;
        end
        if (ram_rdata.page == page_q) begin
          slot_d   = scan_q;
          is_hit_d = 1'b1;
          state_d  = S_HIT;
        end else if (scan_last) begin
          state_d = S_DECIDE;
        end else begin
          scan_d = scan_q + IW'(1);
        end
      end
      S_DECIDE: begin
        misses_d = pfr_pkg::sat_inc(misses_q);
        if (filled_q < limit) begin
          ram_we    = 1'b1;
          ram_waddr = filled_q[IW-1:0];
          filled_d  = filled_q + FW'(1);
          state_d   = S_OUT;
        end else begin
          repl_d = 1'b1;
          priority if (policy_q == pfr_pkg::POL_FIFO) begin
            slot_d   = fifo_slot;
            oldest_d = ((FW'(fifo_slot) + FW'(1)) >= filled_q) ? '0 : fifo_slot + IW'(1);
            state_d  = S_VREAD;
          end else if (policy_q == pfr_pkg::POL_LRU) begin
            slot_d  = best_idx_q;
            state_d = S_VREAD;
          end else begin
            lfsr_d        = lfsr_next;
            mod_req.start = 1'b1;
            state_d       = S_MOD;
          end
        end
      end
      S_MOD: begin
        if (mod_rsp.done) begin
          slot_d  = mod_rsp.rem;
          state_d = S_VREAD;
        end
      end
      S_VREAD: begin
        ram_raddr = slot_q;
        state_d   = S_VWRITE;
      end
      S_VWRITE: begin
        evict_d = ram_rdata.page;
        ram_we  = 1'b1;
        state_d = S_OUT;
      end
      S_HIT: begin
        hits_d  = pfr_pkg::sat_inc(hits_q);
        ram_we  = (policy_q == pfr_pkg::POL_LRU);
        state_d = S_OUT;
      end
      S_OUT: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    m_valid_d = m_valid_q;
    if (out_load) begin
      m_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      policy_q  <= pfr_pkg::POL_RANDOM;
      frames_q  <= pfr_pkg::FRAMES_RESET;
      lfsr_q    <= pfr_pkg::SEED_RESET;
      filled_q  <= '0;
      oldest_q  <= '0;
      access_q  <= '0;
      hits_q    <= '0;
      misses_q  <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      policy_q  <= policy_d;
      frames_q  <= frames_d;
      lfsr_q    <= lfsr_d;
      filled_q  <= filled_d;
      oldest_q  <= oldest_d;
      access_q  <= access_d;
      hits_q    <= hits_d;
      misses_q  <= misses_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    page_q     <= page_d;
    scan_q     <= scan_d;
    slot_q     <= slot_d;
    best_q     <= best_d;
    best_idx_q <= best_idx_d;
    is_hit_q   <= is_hit_d;
    repl_q     <= repl_d;
    evict_q    <= evict_d;
    if (out_load) begin
      m_hit_q    <= is_hit_q;
      m_repl_q   <= repl_q;
      m_evict_q  <= evict_q;
      m_hits_q   <= hits_q;
      m_misses_q <= misses_q;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {4'b0, m_misses_q, m_hits_q, m_evict_q};
  assign m_axis_tuser  = {m_repl_q, m_hit_q};

endmodule
